>>> sv/record_frame_deframer_xxh64_macros.svh
// Assertion helpers for the RTL sequencer.
`ifndef RECORD_FRAME_DEFRAMER_XXH64_MACROS_SVH
`define RECORD_FRAME_DEFRAMER_XXH64_MACROS_SVH

// same-cycle implication
`define RFDX_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rfdx check failed");

// next-cycle implication
`define RFDX_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rfdx check failed");

`endif

>>> sv/rfdx_pkg.sv
package rfdx_pkg;

   localparam int SIZE_BITS_DEF = 31;

   localparam logic [63:0] MAGIC_WORD = 64'h24434552454E4F5E;
   localparam logic [63:0] PR1 = 64'h9E3779B185EBCA87;
   localparam logic [63:0] PR2 = 64'hC2B2AE3D27D4EB4F;
   localparam logic [63:0] PR3 = 64'h165667B19E3779F9;
   localparam logic [63:0] PR4 = 64'h85EBCA77C2B2AE63;
   localparam logic [63:0] PR5 = 64'h27D4EB2F165667C5;

   localparam logic [63:0] ACC_INIT0 = PR1 + PR2;
   localparam logic [63:0] ACC_INIT1 = PR2;
   localparam logic [63:0] ACC_INIT2 = 64'd0;
   localparam logic [63:0] ACC_INIT3 = 64'd0 - PR1;

   localparam logic [1:0] KIND_DATA   = 2'd0;
   localparam logic [1:0] KIND_ACCEPT = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;
   localparam logic [1:0] KIND_FINISH = 2'd3;

   localparam logic [2:0] ERR_NONE  = 3'd0;
   localparam logic [2:0] ERR_MAGIC = 3'd1;
   localparam logic [2:0] ERR_RSV   = 3'd2;
   localparam logic [2:0] ERR_SIZE  = 3'd3;
   localparam logic [2:0] ERR_HDIG  = 3'd4;
   localparam logic [2:0] ERR_PDIG  = 3'd5;
   localparam logic [2:0] ERR_TRUNC = 3'd6;

   localparam logic CSR_MAX_FRAMES       = 1'b0;
   localparam logic CSR_FRAMES_PER_BATCH = 1'b1;

   typedef enum logic [5:0] {
      PH_MAGIC = 6'b000001,
      PH_SIZE  = 6'b000010,
      PH_HDIG  = 6'b000100,
      PH_BODY  = 6'b001000,
      PH_PDIG  = 6'b010000,
      PH_HALT  = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [63:0] word;
      logic        last;
      logic        magic_ok;
      logic        rsv_ok;
      logic        size_ok;
   } item_type;

   function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
      return (x << r) | (x >> (64 - r));
   endfunction

   function automatic logic [63:0] bswap64(input logic [63:0] x);
      logic [63:0] r;
      for (int i = 0; i < 8; i++) r[8*i +: 8] = x[8*(7-i) +: 8];
      return r;
   endfunction

   // elaboration-time only
   function automatic logic [63:0] hdr_seed();
      logic [63:0] k;
      logic [63:0] h;
      k = rotl64(MAGIC_WORD * PR2, 31) * PR1;
      h = (PR5 + 64'd16) ^ k;
      return rotl64(h, 27) * PR1 + PR4;
   endfunction

   localparam logic [63:0] HDR_SEED = hdr_seed();

endpackage

>>> sv/rfdx_mul.sv
// 64x64 product, low 64 bits, built from partial products on one 32x32 multiplier.
module rfdx_mul import rfdx_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic        done,
   output logic [63:0] prod
);
   logic [63:0] a_ff, a_in, b_ff, b_in, p_ff, p_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [31:0] ma, mb;
   logic [63:0] m;

   always_comb begin
      ma = (cnt_ff == 2'd2) ? a_ff[63:32] : a_ff[31:0];
      mb = (cnt_ff == 2'd1) ? b_ff[63:32] : b_ff[31:0];
      m = ma * mb;
      a_in = a_ff;
      b_in = b_ff;
      p_in = p_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in = a;
         b_in = b;
         cnt_in = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff == 2'd0) p_in = m;
         else p_in = {p_ff[63:32] + m[31:0], p_ff[31:0]};
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd2) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      p_ff <= p_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign prod = p_ff;
endmodule

>>> sv/rfdx_front.sv
// Takes stream words, tags header checks, and queues them for the back end.
module rfdx_front import rfdx_pkg::*; #(
   parameter int SIZE_BITS = SIZE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic        req_tuser,
   input  logic        pop,
   output logic        head_valid,
   output item_type    head
);
   item_type   q_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   item_type   item;

   always_comb begin
      item.word = req_tdata;
      item.last = req_tuser;
      item.magic_ok = (req_tdata == MAGIC_WORD);
      item.rsv_ok = (req_tdata[31:0] == 32'd0);
      item.size_ok = ((req_tdata[63:32] >> SIZE_BITS) == 32'd0);
      req_tready = (cnt_ff != 2'd2);
      push = req_tvalid && req_tready;
      head_valid = (cnt_ff != 2'd0);
      head = q_ff[rp_ff];
      wp_in = wp_ff ^ push;
      rp_in = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= item;
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

>>> sv/rfdx_back.sv
// Frame sequencer: checks, digests and verdicts, on a shared multiplier.
`include "record_frame_deframer_xxh64_macros.svh"
module rfdx_back import rfdx_pkg::*; #(
   parameter int SIZE_BITS = SIZE_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  item_type     head,
   output logic         pop,
   input  logic         csr_we,
   input  logic [0:0]   csr_addr,
   input  logic [31:0]  csr_wdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast
);
   localparam int BH_W = SIZE_BITS + 1;
   localparam int WR_W = SIZE_BITS - 2;

   typedef enum logic [25:0] {
      ST_IDLE    = 26'd1,
      ST_MWAIT   = 26'd2,
      ST_XR_A    = 26'd4,
      ST_XR_B    = 26'd8,
      ST_AF_LD   = 26'd16,
      ST_AF      = 26'd32,
      ST_A8_B    = 26'd64,
      ST_A8_C    = 26'd128,
      ST_AV_A    = 26'd256,
      ST_AV_B    = 26'd512,
      ST_AV_C    = 26'd1024,
      ST_FS      = 26'd2048,
      ST_FS2     = 26'd4096,
      ST_FM      = 26'd8192,
      ST_FM_B    = 26'd16384,
      ST_FM_C    = 26'd32768,
      ST_FT      = 26'd65536,
      ST_FL      = 26'd131072,
      ST_FL_NEXT = 26'd262144,
      ST_FQ      = 26'd524288,
      ST_F4_A    = 26'd1048576,
      ST_F4_B    = 26'd2097152,
      ST_F4_C    = 26'd4194304,
      ST_FB_A    = 26'd8388608,
      ST_FB_B    = 26'd16777216,
      ST_FB_C    = 26'd33554432
   } state_type;

   state_type state_ff, state_in, mret_ff, mret_in, xr_ret_ff, xr_ret_in, a8_ret_ff, a8_ret_in;
   phase_type phase_ff, phase_in;
   logic hdr_mode_ff, hdr_mode_in, fin_ff, fin_in;
   logic [1:0] idx_ff, idx_in, fill_ff, fill_in;
   logic [63:0] h_ff, h_in, t_ff, t_in, op_a_ff, op_a_in, op_b_ff, op_b_in;
   logic [63:0] pw_ff, pw_in, sw_ff, sw_in;
   logic [3:0] nb_ff, nb_in;
   logic [63:0] acc_ff [4];
   logic [63:0] acc_in [4];
   logic [63:0] lane_ff [3];
   logic [63:0] lane_in [3];
   logic [BH_W-1:0] bytes_ff, bytes_in;
   logic [SIZE_BITS-1:0] fs_ff, fs_in;
   logic [WR_W-1:0] wr_ff, wr_in;
   logic [31:0] fd_ff, fd_in, maxf_ff, maxf_in;
   logic [15:0] bc_ff, bc_in, fpb_ff, fpb_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_kind_ff, rsp_kind_in;
   logic [63:0] rsp_pw_ff, rsp_pw_in;
   logic [3:0] rsp_vb_ff, rsp_vb_in;
   logic [2:0] rsp_err_ff, rsp_err_in;
   logic rsp_bend_ff, rsp_bend_in;
   logic [30:0] rsp_len_ff, rsp_len_in;

   logic mul_start, mul_done;
   logic [63:0] mul_a, mul_b, prod;
   logic rsp_free, rsp_load;
   logic [BH_W-1:0] diff;
   logic [3:0] vb;
   logic [63:0] pwm, d, x;
   logic [BH_W:0] total;
   logic [SIZE_BITS:0] rup;
   logic [15:0] bc_inc, eff;
   logic [31:0] fd_inc;

   rfdx_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .a(mul_a), .b(mul_b),
      .done(mul_done), .prod(prod)
   );

   always_comb begin
      state_in = state_ff;
      mret_in = mret_ff;
      xr_ret_in = xr_ret_ff;
      a8_ret_in = a8_ret_ff;
      phase_in = phase_ff;
      hdr_mode_in = hdr_mode_ff;
      fin_in = fin_ff;
      idx_in = idx_ff;
      fill_in = fill_ff;
      h_in = h_ff;
      t_in = t_ff;
      op_a_in = op_a_ff;
      op_b_in = op_b_ff;
      pw_in = pw_ff;
      sw_in = sw_ff;
      nb_in = nb_ff;
      acc_in = acc_ff;
      lane_in = lane_ff;
      bytes_in = bytes_ff;
      fs_in = fs_ff;
      wr_in = wr_ff;
      fd_in = fd_ff;
      bc_in = bc_ff;
      maxf_in = maxf_ff;
      fpb_in = fpb_ff;
      rsp_kind_in = rsp_kind_ff;
      rsp_pw_in = rsp_pw_ff;
      rsp_vb_in = rsp_vb_ff;
      rsp_err_in = rsp_err_ff;
      rsp_bend_in = rsp_bend_ff;
      rsp_len_in = rsp_len_ff;
      rsp_load = 1'b0;
      mul_start = 1'b0;
      mul_a = 64'd0;
      mul_b = 64'd0;
      pop = 1'b0;

      if (csr_we) begin
         unique case (csr_addr)
            CSR_MAX_FRAMES:       maxf_in = csr_wdata;
            CSR_FRAMES_PER_BATCH: fpb_in = csr_wdata[15:0];
            default:              maxf_in = maxf_ff;
         endcase
      end

      // last-word byte count and masking
      diff = BH_W'(fs_ff) - bytes_ff;
      if (wr_ff != '0) vb = 4'd8;
      else if (diff > BH_W'(8)) vb = 4'd8;
      else vb = diff[3:0];
      for (int i = 0; i < 8; i++)
         pwm[8*i +: 8] = (4'(i) < vb) ? head.word[8*i +: 8] : 8'd0;

      total = {1'b0, bytes_ff} + (BH_W+1)'(nb_ff);
      d = prod ^ (prod >> 32);
      rup = {1'b0, fs_ff} + (SIZE_BITS+1)'(7);
      bc_inc = bc_ff + 16'd1;
      eff = (fpb_ff == 16'd0) ? 16'd1 : fpb_ff;
      fd_inc = fd_ff + 32'd1;
      x = 64'd0;

      rsp_free = !rsp_valid_ff || rsp_tready;

      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid && rsp_free) begin
               pop = 1'b1;
               unique case (phase_ff)
                  PH_MAGIC: begin
                     if (fd_ff >= maxf_ff || head.last) begin
                        rsp_load = 1'b1;
                        rsp_kind_in = KIND_FINISH;
                        rsp_err_in = ERR_NONE;
                        rsp_len_in = 31'd0;
                        phase_in = PH_HALT;
                     end else if (!head.magic_ok) begin
                        rsp_load = 1'b1;
                        rsp_kind_in = KIND_REJECT;
                        rsp_err_in = ERR_MAGIC;
                        rsp_len_in = 31'd0;
                        phase_in = PH_HALT;
                     end else begin
                        fs_in = '0;
                        phase_in = PH_SIZE;
                     end
                  end
                  PH_SIZE: begin
                     if (head.last) begin
                        rsp_load = 1'b1;
                        rsp_kind_in = KIND_FINISH;
                        rsp_err_in = ERR_TRUNC;
                        rsp_len_in = 31'd0;
                        phase_in = PH_HALT;
                     end else if (!head.rsv_ok) begin
                        rsp_load = 1'b1;
                        rsp_kind_in = KIND_REJECT;
                        rsp_err_in = ERR_RSV;
                        rsp_len_in = head.word[62:32];
                        phase_in = PH_HALT;
                     end else if (!head.size_ok) begin
                        rsp_load = 1'b1;
                        rsp_kind_in = KIND_REJECT;
                        rsp_err_in = ERR_SIZE;
                        rsp_len_in = 31'd0;
                        phase_in = PH_HALT;
                     end else begin
                        fs_in = head.word[32 +: SIZE_BITS];
                        phase_in = PH_HDIG;
                     end
                  end
                  PH_HDIG: begin
                     if (head.last) begin
                        rsp_load = 1'b1;
                        rsp_kind_in = KIND_FINISH;
                        rsp_err_in = ERR_TRUNC;
                        rsp_len_in = 31'd0;
                        phase_in = PH_HALT;
                     end else begin
                        // magic lane is folded into HDR_SEED
                        sw_in = bswap64(head.word);
                        h_in = HDR_SEED;
                        op_a_in = 64'd0;
                        op_b_in = 64'(fs_ff) << 32;
                        xr_ret_in = ST_A8_B;
                        a8_ret_in = ST_AV_A;
                        hdr_mode_in = 1'b1;
                        state_in = ST_XR_A;
                     end
                  end
                  PH_BODY: begin
                     if (head.last) begin
                        rsp_load = 1'b1;
                        rsp_kind_in = KIND_REJECT;
                        rsp_err_in = ERR_TRUNC;
                        rsp_len_in = 31'(fs_ff);
                        phase_in = PH_HALT;
                     end else begin
                        rsp_load = 1'b1;
                        rsp_kind_in = KIND_DATA;
                        rsp_pw_in = pwm;
                        rsp_vb_in = vb;
                        rsp_err_in = ERR_NONE;
                        rsp_len_in = 31'd0;
                        hdr_mode_in = 1'b0;
                        if (wr_ff == '0 && vb != 4'd8) begin
                           pw_in = pwm;
                           nb_in = vb;
                           state_in = ST_FS;
                        end else begin
                           fin_in = (wr_ff == '0);
                           if (wr_ff != '0) wr_in = wr_ff - WR_W'(1);
                           bytes_in = bytes_ff + BH_W'(8);
                           if (fill_ff != 2'd3) begin
                              lane_in[fill_ff] = pwm;
                              fill_in = fill_ff + 2'd1;
                              if (wr_ff == '0) begin
                                 pw_in = 64'd0;
                                 nb_in = 4'd0;
                                 state_in = ST_FS;
                              end
                           end else begin
                              fill_in = 2'd0;
                              pw_in = pwm;
                              idx_in = 2'd0;
                              state_in = ST_AF_LD;
                           end
                        end
                     end
                  end
                  PH_PDIG: begin
                     rsp_load = 1'b1;
                     rsp_len_in = 31'(fs_ff);
                     rsp_pw_in = 64'd0;
                     rsp_vb_in = 4'd0;
                     rsp_bend_in = 1'b0;
                     if (head.last) begin
                        rsp_kind_in = KIND_REJECT;
                        rsp_err_in = ERR_TRUNC;
                        phase_in = PH_HALT;
                     end else if (bswap64(head.word) != acc_ff[0]) begin
                        rsp_kind_in = KIND_REJECT;
                        rsp_err_in = ERR_PDIG;
                        phase_in = PH_HALT;
                     end else begin
                        rsp_kind_in = KIND_ACCEPT;
                        rsp_err_in = ERR_NONE;
                        fd_in = fd_inc;
                        bc_in = bc_inc;
                        if (bc_inc >= eff || fd_inc >= maxf_ff) begin
                           rsp_bend_in = 1'b1;
                           bc_in = 16'd0;
                        end
                        acc_in[0] = ACC_INIT0;
                        acc_in[1] = ACC_INIT1;
                        acc_in[2] = ACC_INIT2;
                        acc_in[3] = ACC_INIT3;
                        fill_in = 2'd0;
                        bytes_in = '0;
                        phase_in = PH_MAGIC;
                     end
                  end
                  default: ;
               endcase
               if (rsp_kind_in != KIND_DATA) begin
                  rsp_pw_in = 64'd0;
                  rsp_vb_in = 4'd0;
               end
               if (rsp_kind_in != KIND_ACCEPT) rsp_bend_in = 1'b0;
            end
         end
         ST_MWAIT: if (mul_done) state_in = mret_ff;
         ST_XR_A: begin
            mul_start = 1'b1;
            mul_a = op_b_ff;
            mul_b = PR2;
            mret_in = ST_XR_B;
            state_in = ST_MWAIT;
         end
         ST_XR_B: begin
            mul_start = 1'b1;
            mul_a = rotl64(op_a_ff + prod, 31);
            mul_b = PR1;
            mret_in = xr_ret_ff;
            state_in = ST_MWAIT;
         end
         ST_AF_LD: begin
            op_a_in = acc_ff[idx_ff];
            op_b_in = (idx_ff == 2'd3) ? pw_ff : lane_ff[idx_ff];
            xr_ret_in = ST_AF;
            state_in = ST_XR_A;
         end
         ST_AF: begin
            acc_in[idx_ff] = prod;
            if (idx_ff != 2'd3) begin
               idx_in = idx_ff + 2'd1;
               state_in = ST_AF_LD;
            end else if (fin_ff) begin
               pw_in = 64'd0;
               nb_in = 4'd0;
               state_in = ST_FS;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_A8_B: begin
            mul_start = 1'b1;
            mul_a = rotl64(h_ff ^ prod, 27);
            mul_b = PR1;
            mret_in = ST_A8_C;
            state_in = ST_MWAIT;
         end
         ST_A8_C: begin
            h_in = prod + PR4;
            state_in = a8_ret_ff;
         end
         ST_AV_A: begin
            mul_start = 1'b1;
            mul_a = h_ff ^ (h_ff >> 33);
            mul_b = PR2;
            mret_in = ST_AV_B;
            state_in = ST_MWAIT;
         end
         ST_AV_B: begin
            mul_start = 1'b1;
            mul_a = prod ^ (prod >> 29);
            mul_b = PR3;
            mret_in = ST_AV_C;
            state_in = ST_MWAIT;
         end
         ST_AV_C: begin
            state_in = ST_IDLE;
            if (!hdr_mode_ff) begin
               acc_in[0] = d;
               phase_in = PH_PDIG;
            end else if (d != sw_ff) begin
               rsp_load = 1'b1;
               rsp_kind_in = KIND_REJECT;
               rsp_err_in = ERR_HDIG;
               rsp_pw_in = 64'd0;
               rsp_vb_in = 4'd0;
               rsp_bend_in = 1'b0;
               rsp_len_in = 31'(fs_ff);
               phase_in = PH_HALT;
            end else begin
               acc_in[0] = ACC_INIT0;
               acc_in[1] = ACC_INIT1;
               acc_in[2] = ACC_INIT2;
               acc_in[3] = ACC_INIT3;
               fill_in = 2'd0;
               bytes_in = '0;
               if (fs_ff == '0) begin
                  hdr_mode_in = 1'b0;
                  pw_in = 64'd0;
                  nb_in = 4'd0;
                  state_in = ST_FS;
               end else begin
                  wr_in = rup[SIZE_BITS:3] - WR_W'(1);
                  phase_in = PH_BODY;
               end
            end
         end
         ST_FS: begin
            if (total >= (BH_W+1)'(32)) begin
               h_in = rotl64(acc_ff[0], 1) + rotl64(acc_ff[1], 7);
               t_in = rotl64(acc_ff[2], 12) + rotl64(acc_ff[3], 18);
               state_in = ST_FS2;
            end else begin
               h_in = PR5;
               state_in = ST_FT;
            end
         end
         ST_FS2: begin
            h_in = h_ff + t_ff;
            idx_in = 2'd0;
            state_in = ST_FM;
         end
         ST_FM: begin
            op_a_in = 64'd0;
            op_b_in = acc_ff[idx_ff];
            xr_ret_in = ST_FM_B;
            state_in = ST_XR_A;
         end
         ST_FM_B: begin
            mul_start = 1'b1;
            mul_a = h_ff ^ prod;
            mul_b = PR1;
            mret_in = ST_FM_C;
            state_in = ST_MWAIT;
         end
         ST_FM_C: begin
            h_in = prod + PR4;
            idx_in = idx_ff + 2'd1;
            state_in = (idx_ff == 2'd3) ? ST_FT : ST_FM;
         end
         ST_FT: begin
            h_in = h_ff + 64'(total);
            idx_in = 2'd0;
            state_in = ST_FL;
         end
         ST_FL: begin
            if (idx_ff < fill_ff) begin
               op_a_in = 64'd0;
               op_b_in = lane_ff[idx_ff];
               xr_ret_in = ST_A8_B;
               a8_ret_in = ST_FL_NEXT;
               state_in = ST_XR_A;
            end else begin
               state_in = ST_FQ;
            end
         end
         ST_FL_NEXT: begin
            idx_in = idx_ff + 2'd1;
            state_in = ST_FL;
         end
         ST_FQ: begin
            if (nb_ff >= 4'd4) state_in = ST_F4_A;
            else if (nb_ff != 4'd0) state_in = ST_FB_A;
            else state_in = ST_AV_A;
         end
         ST_F4_A: begin
            mul_start = 1'b1;
            mul_a = {32'd0, pw_ff[31:0]};
            mul_b = PR1;
            mret_in = ST_F4_B;
            state_in = ST_MWAIT;
         end
         ST_F4_B: begin
            mul_start = 1'b1;
            mul_a = rotl64(h_ff ^ prod, 23);
            mul_b = PR2;
            mret_in = ST_F4_C;
            state_in = ST_MWAIT;
         end
         ST_F4_C: begin
            h_in = prod + PR3;
            pw_in = pw_ff >> 32;
            nb_in = nb_ff - 4'd4;
            state_in = ST_FQ;
         end
         ST_FB_A: begin
            mul_start = 1'b1;
            mul_a = {56'd0, pw_ff[7:0]};
            mul_b = PR5;
            mret_in = ST_FB_B;
            state_in = ST_MWAIT;
         end
         ST_FB_B: begin
            x = h_ff ^ prod;
            mul_start = 1'b1;
            mul_a = rotl64(x, 11);
            mul_b = PR1;
            mret_in = ST_FB_C;
            state_in = ST_MWAIT;
         end
         ST_FB_C: begin
            h_in = prod;
            pw_in = pw_ff >> 8;
            nb_in = nb_ff - 4'd1;
            state_in = ST_FQ;
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (rsp_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      mret_ff <= mret_in;
      xr_ret_ff <= xr_ret_in;
      a8_ret_ff <= a8_ret_in;
      hdr_mode_ff <= hdr_mode_in;
      fin_ff <= fin_in;
      idx_ff <= idx_in;
      h_ff <= h_in;
      t_ff <= t_in;
      op_a_ff <= op_a_in;
      op_b_ff <= op_b_in;
      pw_ff <= pw_in;
      sw_ff <= sw_in;
      nb_ff <= nb_in;
      lane_ff <= lane_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_pw_ff <= rsp_pw_in;
      rsp_vb_ff <= rsp_vb_in;
      rsp_err_ff <= rsp_err_in;
      rsp_bend_ff <= rsp_bend_in;
      rsp_len_ff <= rsp_len_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_MAGIC;
         fill_ff <= 2'd0;
         acc_ff[0] <= ACC_INIT0;
         acc_ff[1] <= ACC_INIT1;
         acc_ff[2] <= ACC_INIT2;
         acc_ff[3] <= ACC_INIT3;
         bytes_ff <= '0;
         fs_ff <= '0;
         wr_ff <= '0;
         fd_ff <= 32'd0;
         bc_ff <= 16'd0;
         maxf_ff <= 32'hFFFFFFFF;
         fpb_ff <= 16'd64;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         fill_ff <= fill_in;
         acc_ff <= acc_in;
         bytes_ff <= bytes_in;
         fs_ff <= fs_in;
         wr_ff <= wr_in;
         fd_ff <= fd_in;
         bc_ff <= bc_in;
         maxf_ff <= maxf_in;
         fpb_ff <= fpb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = rsp_kind_ff;
   assign rsp_tlast = rsp_bend_ff;
   assign rsp_tdata = {2'b00, rsp_len_ff, rsp_err_ff, rsp_vb_ff, rsp_pw_ff};

   `RFDX_ASSERT_IMP(a_done_in_wait, clock, reset, mul_done, state_ff == ST_MWAIT)
   `RFDX_ASSERT_IMP(a_pop_idle, clock, reset, pop, state_ff == ST_IDLE)
   `RFDX_ASSERT_IMP(a_no_overrun, clock, reset, rsp_load, !rsp_valid_ff || rsp_tready)
   `RFDX_ASSERT_NXT(a_halt_stays, clock, reset, phase_ff == PH_HALT, phase_ff == PH_HALT)
endmodule

>>> sv/record_frame_deframer_xxh64.sv
// Channel   Dir  Handshake              Payload
// req_      in   req_tvalid/req_tready  tdata stream_word, tuser stream_end
// rsp_      out  rsp_tvalid/rsp_tready  tdata word/count/error/length, tuser kind, tlast
// csr_      in   csr_we                 csr_addr register index, csr_wdata value
//
// Header and size words and the digest-check word are checked as they are taken;
// the header digest word first recomputes the header digest. Most payload words
// are taken directly; every fourth runs four stripe rounds and the last one
// finalizes the digest. Each 64-bit product is built on the
// one shared 32x32 multiplier. Reset is synchronous; a two-word queue lets
// input flow while the sequencer or the result register is stalled.
module record_frame_deframer_xxh64 import rfdx_pkg::*; #(
   parameter int SIZE_BITS = SIZE_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // stream_word
   input  logic         req_tuser,   // stream_end
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // payload_word[63:0], valid_bytes[67:64], error_code[70:68], payload_length[101:71]
   output logic [103:0] rsp_tdata,
   output logic [1:0]   rsp_tuser,   // kind
   output logic         rsp_tlast,   // batch_end
   input  logic         csr_we,
   input  logic [0:0]   csr_addr,
   input  logic [31:0]  csr_wdata
);
   logic     head_valid, pop;
   item_type head;

   rfdx_front #(.SIZE_BITS(SIZE_BITS)) u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .pop(pop), .head_valid(head_valid), .head(head)
   );

   rfdx_back #(.SIZE_BITS(SIZE_BITS)) u_back (
      .clock(clock), .reset(reset),
      .head_valid(head_valid), .head(head), .pop(pop),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );
endmodule

>>> tb/sv/record_frame_deframer_xxh64_checker.sv
`timescale 1ns / 1ps

package rfdx_tb_pkg;
   import rfdx_pkg::*;

   typedef enum logic [2:0] {
      ST_MAGIC, ST_SIZE, ST_HDIG, ST_BODY, ST_PDIG, ST_HALT
   } parse_state_type;

   typedef byte unsigned byte_q_type[$];

   function automatic logic [63:0] rol64(input logic [63:0] x, input int r);
      return (x << r) | (x >> (64 - r));
   endfunction

   function automatic logic [63:0] swap_bytes(input logic [63:0] x);
      logic [63:0] r;
      for (int i = 0; i < 8; i++) r[8*i +: 8] = x[8*(7-i) +: 8];
      return r;
   endfunction

   function automatic logic [63:0] mix_lane(input logic [63:0] acc, input logic [63:0] lane);
      logic [63:0] a;
      a = acc + lane * PR2;
      return rol64(a, 31) * PR1;
   endfunction

   function automatic logic [63:0] load_le(input byte_q_type q, input int p, input int n);
      logic [63:0] v;
      v = '0;
      for (int i = 0; i < n; i++) v[8*i +: 8] = q[p+i];
      return v;
   endfunction

   // XXH64 with seed zero over a byte string
   function automatic logic [63:0] xxh64_digest(input byte_q_type q);
      logic [63:0] h;
      logic [63:0] v[4];
      int len;
      int p;
      len = q.size();
      p = 0;
      if (len >= 32) begin
         v[0] = PR1 + PR2; v[1] = PR2; v[2] = 64'd0; v[3] = 64'd0 - PR1;
         while (p + 32 <= len) begin
            for (int i = 0; i < 4; i++) v[i] = mix_lane(v[i], load_le(q, p + 8*i, 8));
            p += 32;
         end
         h = rol64(v[0], 1) + rol64(v[1], 7) + rol64(v[2], 12) + rol64(v[3], 18);
         for (int i = 0; i < 4; i++) begin
            h ^= mix_lane(64'd0, v[i]);
            h = h * PR1 + PR4;
         end
      end else begin
         h = PR5;
      end
      h += 64'(len);
      while (p + 8 <= len) begin
         h ^= mix_lane(64'd0, load_le(q, p, 8));
         h = rol64(h, 27) * PR1 + PR4;
         p += 8;
      end
      if (p + 4 <= len) begin
         h ^= load_le(q, p, 4) * PR1;
         h = rol64(h, 23) * PR2 + PR3;
         p += 4;
      end
      while (p < len) begin
         h ^= 64'(q[p]) * PR5;
         h = rol64(h, 11) * PR1;
         p++;
      end
      h ^= h >> 33; h *= PR2;
      h ^= h >> 29; h *= PR3;
      h ^= h >> 32;
      return h;
   endfunction

   function automatic void append_word(ref byte_q_type q, input logic [63:0] w, input int n);
      for (int i = 0; i < n; i++) q.push_back(w[8*i +: 8]);
   endfunction

   function automatic logic [63:0] header_check_word(input logic [30:0] size);
      byte_q_type q;
      append_word(q, MAGIC_WORD, 8);
      append_word(q, {1'b0, size, 32'd0}, 8);
      return swap_bytes(xxh64_digest(q));
   endfunction
endpackage

module record_frame_deframer_xxh64_checker
   import rfdx_pkg::*;
   import rfdx_tb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [63:0]  req_tdata,
   input  logic         req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [103:0] rsp_tdata,
   input  logic [1:0]   rsp_tuser,
   input  logic         rsp_tlast,
   input  logic         csr_we,
   input  logic [0:0]   csr_addr,
   input  logic [31:0]  csr_wdata,
   output int           errors,
   output int           pending,
   output int           frames_ok,
   output int           data_words
);

   typedef struct {
      logic [1:0]  kind;
      logic [63:0] word;
      logic [3:0]  nbytes;
      logic [2:0]  err;
      logic        bend;
      logic [30:0] len;
   } verdict_type;

   verdict_type     expected_q[$];
   parse_state_type state;
   logic [31:0]  frame_limit;
   logic [15:0]  batch_limit;
   logic [30:0]  frame_len;
   logic [31:0]  got_bytes;
   logic [31:0]  frames_done;
   logic [15:0]  batch_cnt;
   logic [63:0]  body_digest;
   byte_q_type   body;

   function automatic void push_result(input logic [1:0] k, input logic [63:0] w,
                                       input logic [3:0] n, input logic [2:0] e,
                                       input logic b, input logic [30:0] l);
      verdict_type v;
      v.kind = k; v.word = w; v.nbytes = n; v.err = e; v.bend = b; v.len = l;
      expected_q.push_back(v);
   endfunction

   function automatic void fail_frame(input logic [2:0] e, input logic [30:0] l);
      state = ST_HALT;
      push_result(KIND_REJECT, 64'd0, 4'd0, e, 1'b0, l);
   endfunction

   task automatic parse_word(input logic [63:0] w, input logic fin);
      logic [31:0] sz;
      logic [31:0] nb;
      logic [63:0] pw;
      logic [15:0] eff;
      logic        bend;
      case (state)
         ST_MAGIC: begin
            if (frames_done >= frame_limit || fin) begin
               state = ST_HALT;
               push_result(KIND_FINISH, 64'd0, 4'd0, ERR_NONE, 1'b0, 31'd0);
            end else if (w != MAGIC_WORD) begin
               fail_frame(ERR_MAGIC, 31'd0);
            end else begin
               frame_len = '0;
               state = ST_SIZE;
            end
         end
         ST_SIZE, ST_HDIG: begin
            if (fin) begin
               state = ST_HALT;
               push_result(KIND_FINISH, 64'd0, 4'd0, ERR_TRUNC, 1'b0, 31'd0);
            end else if (state == ST_SIZE) begin
               sz = w[63:32];
               if (w[31:0] != 32'd0) fail_frame(ERR_RSV, sz[30:0]);
               else if (sz[31]) fail_frame(ERR_SIZE, 31'd0);
               else begin
                  frame_len = sz[30:0];
                  state = ST_HDIG;
               end
            end else if (w != header_check_word(frame_len)) begin
               fail_frame(ERR_HDIG, frame_len);
            end else begin
               body.delete();
               got_bytes = '0;
               if (frame_len == 31'd0) begin
                  body_digest = xxh64_digest(body);
                  state = ST_PDIG;
               end else begin
                  state = ST_BODY;
               end
            end
         end
         ST_BODY: begin
            if (fin) fail_frame(ERR_TRUNC, frame_len);
            else begin
               nb = {1'b0, frame_len} - got_bytes;
               if (nb > 32'd8) nb = 32'd8;
               pw = '0;
               for (int i = 0; i < 8; i++) if (i < nb) pw[8*i +: 8] = w[8*i +: 8];
               append_word(body, pw, int'(nb));
               got_bytes += nb;
               if (got_bytes == {1'b0, frame_len}) begin
                  body_digest = xxh64_digest(body);
                  state = ST_PDIG;
               end
               push_result(KIND_DATA, pw, nb[3:0], ERR_NONE, 1'b0, 31'd0);
            end
         end
         ST_PDIG: begin
            if (fin) fail_frame(ERR_TRUNC, frame_len);
            else if (swap_bytes(w) != body_digest) fail_frame(ERR_PDIG, frame_len);
            else begin
               frames_done++;
               batch_cnt++;
               eff = (batch_limit == 16'd0) ? 16'd1 : batch_limit;
               bend = (batch_cnt >= eff) || (frames_done >= frame_limit);
               if (bend) batch_cnt = '0;
               state = ST_MAGIC;
               push_result(KIND_ACCEPT, 64'd0, 4'd0, ERR_NONE, bend, frame_len);
            end
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      verdict_type v;
      if (reset) begin
         expected_q.delete();
         state = ST_MAGIC;
         frame_limit = 32'hFFFF_FFFF;
         batch_limit = 16'd64;
         frame_len = '0;
         got_bytes = '0;
         frames_done = '0;
         batch_cnt = '0;
         errors = 0;
         frames_ok = 0;
         data_words = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               $error("unexpected result word: kind %0d", rsp_tuser);
               errors++;
            end else begin
               v = expected_q.pop_front();
               check_field("kind", 64'(v.kind), 64'(rsp_tuser));
               check_field("payload_word", v.word, rsp_tdata[63:0]);
               check_field("valid_bytes", 64'(v.nbytes), 64'(rsp_tdata[67:64]));
               check_field("error_code", 64'(v.err), 64'(rsp_tdata[70:68]));
               check_field("payload_length", 64'(v.len), 64'(rsp_tdata[101:71]));
               check_field("batch_end", 64'(v.bend), 64'(rsp_tlast));
               if (v.kind == KIND_ACCEPT) frames_ok++;
               if (v.kind == KIND_DATA) data_words++;
            end
         end
         if (csr_we) begin
            if (csr_addr == CSR_MAX_FRAMES) frame_limit = csr_wdata;
            else batch_limit = csr_wdata[15:0];
         end
         if (req_tvalid && req_tready) parse_word(req_tdata, req_tuser);
      end
      pending = expected_q.size();
   end

endmodule

>>> tb/sv/record_frame_deframer_xxh64_tb.sv
`timescale 1ns / 1ps

module record_frame_deframer_xxh64_tb;
   import rfdx_pkg::*;
   import rfdx_tb_pkg::*;

   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 300;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [63:0]  req_tdata;
   logic         req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [103:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_we;
   logic [0:0]   csr_addr;
   logic [31:0]  csr_wdata;

   int errors, pending, frames_ok, data_words;
   int send_idle, recv_idle;
   int words_sent;
   int quiet_cycles;
   int ending;

   record_frame_deframer_xxh64 DUT (.*);

   record_frame_deframer_xxh64_checker u_checker (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast,
      .csr_we, .csr_addr, .csr_wdata,
      .errors, .pending, .frames_ok, .data_words
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(negedge clock) rsp_tready <= !reset && ($urandom_range(99) >= recv_idle);

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("stalled: nothing accepted for %0d cycles", STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic put_word(input logic [63:0] w, input logic fin);
      logic ready_now;
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      req_tuser  <= fin;
      // ready only moves at the rising edge, so the value here holds for it
      do begin
         ready_now = req_tready;
         @(negedge clock);
      end while (!ready_now);
      words_sent++;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // cut: 0 whole frame, 1 end inside body, 2 end at digest word, 3 bad digest
   task automatic send_frame(input int size, input int fill, input int cut);
      byte_q_type  q;
      logic [63:0] w;
      int          n;
      put_word(MAGIC_WORD, 1'b0);
      put_word({1'b0, 31'(size), 32'd0}, 1'b0);
      put_word(header_check_word(31'(size)), 1'b0);
      for (int p = 0; p < size; p += 8) begin
         if (cut == 1 && p + 8 >= size && p > 0) begin
            put_word(rand64(), 1'b1);
            return;
         end
         w = (fill == 1) ? '1 : (fill == 2) ? '0 : rand64();
         n = (size - p > 8) ? 8 : size - p;
         append_word(q, w, n);
         put_word(w, 1'b0);
      end
      w = swap_bytes(xxh64_digest(q));
      if (cut == 2) put_word(rand64(), 1'b1);
      else if (cut == 3) put_word(w ^ (64'd1 << $urandom_range(63)), 1'b0);
      else put_word(w, 1'b0);
   endtask

   task automatic drain_and_write(input logic [0:0] idx, input logic [31:0] val);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic random_frames(input int target);
      int sz;
      while (words_sent < target) begin
         sz = ($urandom_range(19) == 0) ? $urandom_range(400) : $urandom_range(48);
         send_frame(sz, 0, 0);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0; req_tdata = '0; req_tuser = 1'b0;
      csr_we = 1'b0; csr_addr = '0; csr_wdata = '0;
      send_idle = 11; recv_idle = 62;
      words_sent = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      drain_and_write(CSR_MAX_FRAMES, 32'hFFFF_FFFF);
      drain_and_write(CSR_FRAMES_PER_BATCH, 32'd1);
      // size edges around word and stripe boundaries, solid and random fill patterns
      send_frame(0, 0, 0);
      send_frame(1, 1, 0);
      send_frame(4, 2, 0);
      send_frame(7, 0, 0);
      send_frame(8, 1, 0);
      send_frame(9, 0, 0);
      send_frame(31, 2, 0);
      send_frame(32, 1, 0);
      send_frame(33, 0, 0);
      send_frame(40, 0, 0);
      random_frames(500);

      drain_and_write(CSR_FRAMES_PER_BATCH, 32'd65535);
      send_idle = 62; recv_idle = 11;
      random_frames(900);

      drain_and_write(CSR_FRAMES_PER_BATCH, 32'd0);
      send_idle = 0; recv_idle = 0;
      random_frames(1200);
      drain_and_write(CSR_FRAMES_PER_BATCH, 32'd3);
      random_frames(1500);

      // the block halts for good after this, so one way out per run
      ending = $urandom_range(10);
      case (ending)
         0: begin
            drain_and_write(CSR_MAX_FRAMES, 32'(frames_ok + 1));
            send_frame($urandom_range(20), 0, 0);
            put_word(rand64(), 1'b0);
         end
         1: put_word(rand64(), 1'b1);
         2: put_word(MAGIC_WORD ^ (64'd1 << $urandom_range(63)), 1'b0);
         3: begin
            put_word(MAGIC_WORD, 1'b0);
            put_word({$urandom(), $urandom_range(32'hFFFF_FFFF, 1)}, 1'b0);
         end
         4: begin
            put_word(MAGIC_WORD, 1'b0);
            put_word({1'b1, 31'($urandom()), 32'd0}, 1'b0);
         end
         5: begin
            put_word(MAGIC_WORD, 1'b0);
            put_word(rand64(), 1'b1);
         end
         6: begin
            put_word(MAGIC_WORD, 1'b0);
            put_word({32'd16, 32'd0}, 1'b0);
            put_word(rand64(), 1'b1);
         end
         7: begin
            put_word(MAGIC_WORD, 1'b0);
            put_word({32'd16, 32'd0}, 1'b0);
            put_word(header_check_word(31'd16) ^ 64'h1, 1'b0);
         end
         8: send_frame($urandom_range(9, 40), 0, 1);
         9: send_frame($urandom_range(40), 0, 2);
         default: send_frame($urandom_range(40), 0, 3);
      endcase
      // halted block must stay silent
      repeat (3) put_word(rand64(), 1'($urandom_range(1)));
      req_tvalid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("covered %0d input words, %0d frames accepted, %0d payload words",
               words_sent, frames_ok, data_words);
      $display("closing case %0d, batch sizes 1/65535/0/3, frame limit", ending);
      if (errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule
